// ----- design/assert_macros.svh -----
// concurrent assertion helpers, clocked on clock and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/adst_pkg.sv -----
package adst_pkg;

   localparam int SAMPLE_W = 10;
   localparam int REQ_W    = 16;
   localparam int RSP_W    = 40;
   localparam int CSR_W    = 10;
   localparam int CSR_A_W  = 2;
   localparam int THR_W    = 4;

   localparam logic [1:0] CH_WIPER  = 2'd0;
   localparam logic [1:0] CH_TOUCH  = 2'd1;
   localparam logic [1:0] CH_GROUND = 2'd2;

   localparam logic [1:0] PH_CHARGE  = 2'd1;
   localparam logic [1:0] PH_RELEASE = 2'd2;
   localparam logic [1:0] PH_SAMPLE  = 2'd3;

   localparam logic [1:0] DRIVE_HOLD = 2'd0;
   localparam logic [1:0] DRIVE_ON   = 2'd1;
   localparam logic [1:0] DRIVE_OFF  = 2'd2;

   localparam logic [CSR_A_W-1:0] REG_HALT      = 2'd0;
   localparam logic [CSR_A_W-1:0] REG_TOUCH_MIN = 2'd1;
   localparam logic [CSR_A_W-1:0] REG_TOUCH_MAX = 2'd2;
   localparam logic [CSR_A_W-1:0] REG_THRESHOLD = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic write;
      logic scan;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_sample;
      logic scan_last;
      logic out_free;
   } stat_type;

endpackage

// ----- design/adst_ram.sv -----
module adst_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 8
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/adst_ctrl.sv -----
`include "assert_macros.svh"

module adst_ctrl import adst_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat_i,
   output cmd_type  cmd_o
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = stat_i.is_sample ? ST_WRITE : ST_EMIT;
            end
         end
         ST_WRITE: state_in = ST_SCAN;
         ST_SCAN: begin
            if (stat_i.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_EMIT;
         ST_EMIT: begin
            if (stat_i.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_o      = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd_o.load = req_tvalid;
         end
         ST_WRITE: cmd_o.write = 1'b1;
         ST_SCAN:  cmd_o.scan  = 1'b1;
         ST_DRAIN: cmd_o       = '0;
         ST_EMIT:  cmd_o.emit  = stat_i.out_free;
         default:  cmd_o       = '0;
      endcase
   end

   `ASSERT_SAME(a_emit_free, cmd_o.emit, stat_i.out_free, "word emitted into full slot")
   `ASSERT_NEXT(a_write_scan, state_ff == ST_WRITE, state_ff == ST_SCAN, "write not followed by scan")
   `ASSERT_NEXT(a_scan_end, (state_ff == ST_SCAN) && stat_i.scan_last, state_ff == ST_DRAIN,
                "scan did not end")

endmodule

// ----- design/adst_dp.sv -----
module adst_dp import adst_pkg::*; #(
   parameter int WINDOW_SIZE = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [REQ_W-1:0]    req_tdata,
   input  logic                csr_we,
   input  logic [CSR_A_W-1:0]  csr_addr,
   input  logic [CSR_W-1:0]    csr_wdata,
   input  cmd_type             cmd_i,
   output stat_type            stat_o,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [RSP_W-1:0]    rsp_tdata
);

   localparam int ADDR_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
   localparam int CMP_W  = (CNT_W > THR_W) ? CNT_W : THR_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_SIZE - 1);

   logic                   halt_ff, halt_in;
   logic [SAMPLE_W-1:0]    min_ff, min_in;
   logic [SAMPLE_W-1:0]    max_ff, max_in;
   logic [THR_W-1:0]       thr_ff, thr_in;
   logic [1:0]             chan_ff, chan_in;
   logic [1:0]             phase_ff, phase_in;
   logic [ADDR_W-1:0]      ptr_ff, ptr_in;
   logic [WINDOW_SIZE-1:0] valid_ff, valid_in;
   logic                   flag_ff, flag_in;
   logic [SAMPLE_W-1:0]    touch_ff, touch_in;
   logic [SAMPLE_W-1:0]    pos_ff, pos_in;
   logic [SAMPLE_W-1:0]    sample_ff, sample_in;
   logic [ADDR_W-1:0]      idx_ff, idx_in;
   logic                   pend_ff, pend_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   out_valid_ff, out_valid_in;
   logic [RSP_W-1:0]       out_data_ff, out_data_in;

   logic [SAMPLE_W-1:0]    ram_rdata;
   logic [SAMPLE_W-1:0]    entry;
   logic                   in_range;
   logic                   is_sample;
   logic [1:0]             next_chan;
   logic [1:0]             next_phase;
   logic [1:0]             drive;
   logic                   sampled;
   logic                   pos_upd;
   logic [SAMPLE_W-1:0]    pos_new;
   logic                   flag_new;

   adst_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW_SIZE)
   ) u_ring (
      .clock (clock),
      .we    (cmd_i.write),
      .waddr (ptr_ff),
      .wdata (sample_ff),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   assign is_sample = (chan_ff == CH_TOUCH) && (phase_ff == PH_SAMPLE);
   assign entry     = rd_valid_ff ? ram_rdata : '0;
   assign in_range  = (entry > min_ff) && (entry < max_ff);

   // channel sequencing
   always_comb begin
      next_chan  = CH_TOUCH;
      next_phase = phase_ff;
      drive      = DRIVE_HOLD;
      sampled    = 1'b0;
      pos_upd    = 1'b0;
      case (chan_ff)
         CH_WIPER: begin
            pos_upd   = 1'b1;
            next_chan = CH_TOUCH;
         end
         CH_TOUCH: begin
            case (phase_ff)
               PH_CHARGE: begin
                  drive      = DRIVE_ON;
                  next_chan  = CH_GROUND;
                  next_phase = PH_RELEASE;
               end
               PH_RELEASE: begin
                  drive      = DRIVE_OFF;
                  next_chan  = CH_GROUND;
                  next_phase = PH_SAMPLE;
               end
               PH_SAMPLE: begin
                  sampled    = 1'b1;
                  next_chan  = CH_WIPER;
                  next_phase = PH_CHARGE;
               end
               default: begin
                  next_chan  = CH_WIPER;
                  next_phase = PH_CHARGE;
               end
            endcase
         end
         default: next_chan = CH_TOUCH;
      endcase
   end

   assign pos_new  = pos_upd ? sample_ff : pos_ff;
   assign flag_new = is_sample ? (CMP_W'(count_ff) >= CMP_W'(thr_ff)) : flag_ff;

   always_comb begin
      halt_in      = halt_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      thr_in       = thr_ff;
      chan_in      = chan_ff;
      phase_in     = phase_ff;
      ptr_in       = ptr_ff;
      valid_in     = valid_ff;
      flag_in      = flag_ff;
      touch_in     = touch_ff;
      pos_in       = pos_ff;
      sample_in    = sample_ff;
      idx_in       = idx_ff;
      pend_in      = cmd_i.scan;
      rd_valid_in  = valid_ff[idx_ff];
      count_in     = count_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;

      if (csr_we) begin
         case (csr_addr)
            REG_HALT:      halt_in = csr_wdata[0];
            REG_TOUCH_MIN: min_in  = csr_wdata[SAMPLE_W-1:0];
            REG_TOUCH_MAX: max_in  = csr_wdata[SAMPLE_W-1:0];
            REG_THRESHOLD: thr_in  = csr_wdata[THR_W-1:0];
            default:       halt_in = halt_ff;
         endcase
      end

      if (cmd_i.load) begin
         sample_in = req_tdata[SAMPLE_W-1:0];
      end

      if (cmd_i.write) begin
         touch_in         = sample_ff;
         valid_in[ptr_ff] = 1'b1;
         ptr_in           = (ptr_ff == LAST_ADDR) ? '0 : ptr_ff + 1'b1;
         idx_in           = '0;
         count_in         = '0;
      end

      if (cmd_i.scan && (idx_ff != LAST_ADDR)) begin
         idx_in = idx_ff + 1'b1;
      end

      if (pend_ff && in_range) begin
         count_in = count_ff + CNT_W'(1);
      end

      if (cmd_i.emit) begin
         chan_in      = next_chan;
         phase_in     = next_phase;
         pos_in       = pos_new;
         flag_in      = flag_new;
         out_valid_in = 1'b1;
         out_data_in  = {4'b0000, ~halt_ff, pos_new[SAMPLE_W-1:2], pos_new, pos_upd,
                         flag_new, touch_ff, sampled, drive, next_chan};
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         halt_ff      <= 1'b0;
         min_ff       <= '0;
         max_ff       <= '1;
         thr_ff       <= THR_W'(5);
         chan_ff      <= CH_WIPER;
         phase_ff     <= PH_CHARGE;
         ptr_ff       <= '0;
         valid_ff     <= '0;
         flag_ff      <= 1'b0;
         touch_ff     <= '0;
         pos_ff       <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rd_valid_ff  <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         halt_ff      <= halt_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         thr_ff       <= thr_in;
         chan_ff      <= chan_in;
         phase_ff     <= phase_in;
         ptr_ff       <= ptr_in;
         valid_ff     <= valid_in;
         flag_ff      <= flag_in;
         touch_ff     <= touch_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rd_valid_ff  <= rd_valid_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      out_data_ff <= out_data_in;
   end

   assign stat_o.is_sample = is_sample;
   assign stat_o.scan_last = (idx_ff == LAST_ADDR);
   assign stat_o.out_free  = ~out_valid_ff | rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ----- design/adc_sequencer_touch_detect.sv -----
// ADC channel sequencer with capacitive touch detection.
// req channel: one finished conversion per word; the sequence steps wiper,
// touch charge, ground, touch release, ground, touch sample, then wiper again.
// rsp channel: exactly one word per accepted conversion, in order.
// csr port: single-cycle writes of halt, touch_min, touch_max and threshold,
// to be made by the user only while no conversion is in flight; the block
// does not enforce this. a conversion that is not a touch sample goes from
// acceptance to the emit step and then to the output register; a touch sample
// first writes the ring, then sweeps it, reading one stored sample per cycle
// from a single-read-port memory to count in-range entries, drains, and emits.
// one conversion is processed at a time; the next is accepted as soon as the
// result is parked in the output register.
// reset: channel returns to wiper, touch phase to charge, ring entries read as
// zero through per-entry valid bits; touch, position and counters clear.
// when the receiver stalls, the result word holds in the output register and
// the block stops at its final step until the register frees up.
module adc_sequencer_touch_detect import adst_pkg::*; #(
   parameter int WINDOW_SIZE = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_W-1:0]   req_tdata,   // sample[9:0], zero pad[15:10]
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // next_channel[1:0], charge_drive[3:2], touch_sampled[4], touch_raw[14:5],
   // touch_detected[15], position_updated[16], position_raw[26:17],
   // position_byte[34:27], restart[35], zero pad[39:36]
   output logic [RSP_W-1:0]   rsp_tdata,
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]   csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   adst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat_i     (stat),
      .cmd_o      (cmd)
   );

   adst_dp #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd_i      (cmd),
      .stat_o     (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
